// ----- hdl/swpr_pkg.sv -----
// ----------------------------------------------------------------------------
// swpr_pkg: shared definitions for the sliding-window percentile range core
// Widths, register indexes, reset values and the structs passed along the
// sorted cell row.
// ----------------------------------------------------------------------------
package swpr_pkg;

	localparam int DATA_W             = 32;
	localparam int WL_W               = 5;
	localparam int KF_W               = 17;
	localparam int CFG_IDX_W          = 2;
	localparam int CFG_DATA_W         = 17;
	localparam int MAX_WINDOW_DEFAULT = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_FRACTION = 2'd1;

	localparam logic [WL_W-1:0] WL_RESET = 5'd12;
	localparam logic [KF_W-1:0] KF_RESET = 17'd54395;

	// Q1.16 fixed point: one and one half.
	localparam logic [KF_W-1:0] Q_ONE  = 17'h10000;
	localparam logic [KF_W-1:0] Q_HALF = 17'h08000;

	// What a cell shows its neighbors.
	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              occ;  // cell holds a sample
		logic              gt;   // held sample is greater than the new one
		logic              del;  // the oldest sample sits here or below
	} link_t;

	// Rank selection results, accumulated up the row.
	typedef struct packed {
		logic [DATA_W-1:0] low;
		logic [DATA_W-1:0] high;
	} sel_t;

	// Commands broadcast to every cell.
	typedef struct packed {
		logic              remove;
		logic              insert;
		logic [DATA_W-1:0] sample;
	} ctrl_t;

endpackage

// ----- hdl/swpr_cell.sv -----
// ----------------------------------------------------------------------------
// swpr_cell: one slot of the sorted sample row
// Holds a sample and its age, closes the gap left by the oldest sample and
// makes room for a new sample in sorted position.
// ----------------------------------------------------------------------------
module swpr_cell #(
	parameter int MAX_WINDOW = swpr_pkg::MAX_WINDOW_DEFAULT,
	parameter int IDX        = 0,
	localparam int CW        = $clog2(MAX_WINDOW + 1),
	localparam int AW        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
	input  logic                  clk,
	input  swpr_pkg::ctrl_t       ctrl,
	input  logic [CW-1:0]         count,
	input  logic [AW-1:0]         oldest_age,
	input  logic [CW-1:0]         rank_lo,
	input  logic [CW-1:0]         rank_hi,
	input  swpr_pkg::link_t       below,
	input  logic [AW-1:0]         below_age,
	input  swpr_pkg::link_t       above,
	input  logic [AW-1:0]         above_age,
	input  swpr_pkg::sel_t        sel_in,
	output swpr_pkg::link_t       link,
	output logic [AW-1:0]         age,
	output swpr_pkg::sel_t        sel_out
);

	logic [swpr_pkg::DATA_W-1:0] value_q;
	logic [AW-1:0]               age_q;
	logic                        occ;
	logic                        del_here;
	logic                        gt;
	logic                        ins_here;

	always_comb begin
		occ      = (CW'(IDX) < count);
		del_here = occ && (age_q == oldest_age);
		gt       = occ && (value_q > ctrl.sample);
		// The new sample lands in the lowest cell that is empty or greater.
		ins_here = !below.gt && below.occ && (!occ || gt);

		link.value = value_q;
		link.occ   = occ;
		link.gt    = gt;
		link.del   = below.del || del_here;
		age        = age_q;

		sel_out.low  = sel_in.low  | ((CW'(IDX) == rank_lo) ? value_q : '0);
		sel_out.high = sel_in.high | ((CW'(IDX) == rank_hi) ? value_q : '0);
	end

	always_ff @(posedge clk) begin
		if (ctrl.remove && link.del) begin
			value_q <= above.value;
			age_q   <= above_age;
		end else if (ctrl.insert) begin
			if (below.gt) begin
				value_q <= below.value;
				age_q   <= below_age + AW'(1);
			end else if (ins_here) begin
				value_q <= ctrl.sample;
				age_q   <= '0;
			end else begin
				age_q <= age_q + AW'(1);
			end
		end
	end

endmodule

// ----- hdl/sliding_window_percentile_range_core.sv -----
// ----------------------------------------------------------------------------
// sliding_window_percentile_range_core: trimmed order-statistic range
// Keeps the most recent samples sorted in a row of cells and reports the
// trimmed low and high cut of the window before each new sample.
// ----------------------------------------------------------------------------
// Result: an item's result is registered in the output register as the item
// is accepted. Items: a new item waits until the previous one is inserted;
// the accept cycle removes the oldest sample from the sorted cell row when
// the window is full and the next cycle inserts the new sample.
// Reset: asynchronous; the window is empty, the configuration registers take
// their defaults and the cells need no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_percentile_range_core #(
	parameter int MAX_WINDOW = swpr_pkg::MAX_WINDOW_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [swpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swpr_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [swpr_pkg::DATA_W-1:0]       sample_value,
	// result items
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              range_valid,
	output logic [swpr_pkg::DATA_W-1:0]       range_low,
	output logic [swpr_pkg::DATA_W-1:0]       range_high
);

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LW = (CW > swpr_pkg::WL_W) ? CW : swpr_pkg::WL_W;
	localparam int PW = swpr_pkg::KF_W + CW;   // product width of the discard count
	localparam int DW = PW - 16;               // discard count before the cap

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_INS  = 2'b10
	} state_t;

	state_t                         state_q;
	logic [swpr_pkg::WL_W-1:0]      wl_q;
	logic [swpr_pkg::KF_W-1:0]      kf_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  rank_lo_q;
	logic [CW-1:0]                  rank_hi_q;
	logic [swpr_pkg::DATA_W-1:0]    sample_q;
	logic                           out_valid_q;
	logic                           range_valid_q;
	logic [swpr_pkg::DATA_W-1:0]    range_low_q;
	logic [swpr_pkg::DATA_W-1:0]    range_high_q;

	logic                           cfg_hit;
	logic                           in_acc;
	logic                           full;
	logic [LW-1:0]                  wl_ext;
	logic [CW-1:0]                  len_eff;
	logic [swpr_pkg::KF_W-1:0]      p_eff;
	logic [swpr_pkg::KF_W-1:0]      q_frac;
	logic [CW-1:0]                  n_next;
	logic [PW-1:0]                  prod;
	logic [DW-1:0]                  d_raw;
	logic [CW-1:0]                  d_cap;
	logic [CW-1:0]                  d_next;
	logic [CW-1:0]                  hi_next;
	logic [AW-1:0]                  oldest_age;
	swpr_pkg::ctrl_t                ctrl;

	swpr_pkg::link_t                cell_link [MAX_WINDOW];
	logic [AW-1:0]                  cell_age  [MAX_WINDOW];
	swpr_pkg::sel_t                 sel_chain [MAX_WINDOW+1];

	// A write to either register empties the window; other indexes are ignored.
	assign cfg_hit = cfg_we && ((cfg_index == swpr_pkg::REG_WINDOW_LENGTH) ||
		(cfg_index == swpr_pkg::REG_KEEP_FRACTION));

	// The next item is taken once the row is settled and the output register
	// is free or is being emptied in this cycle.
	assign in_stall = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall));
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		// Window length is saturated into 1..MAX_WINDOW when used.
		wl_ext = LW'(wl_q);
		if (wl_q == '0) begin
			len_eff = CW'(1);
		end else if (wl_ext > LW'(MAX_WINDOW)) begin
			len_eff = CW'(MAX_WINDOW);
		end else begin
			len_eff = CW'(wl_ext);
		end
		full = (count_q == len_eff);

		// Discard count for the window as it will stand after the insertion:
		// round half up of (1 - p) * n, capped at (n - 1) / 2.
		p_eff   = (kf_q > swpr_pkg::Q_ONE) ? swpr_pkg::Q_ONE : kf_q;
		q_frac  = swpr_pkg::Q_ONE - p_eff;
		n_next  = count_q + CW'(1);
		prod    = PW'(q_frac) * PW'(n_next) + PW'(swpr_pkg::Q_HALF);
		d_raw   = prod[PW-1:16];
		d_cap   = (n_next - CW'(1)) >> 1;
		d_next  = (d_raw > DW'(d_cap)) ? d_cap : CW'(d_raw);
		hi_next = n_next - CW'(1) - d_next;

		// Ages of held samples are 0..count-1, so the oldest has count-1.
		oldest_age = AW'(count_q - CW'(1));

		ctrl.remove = in_acc && full;
		ctrl.insert = (state_q == ST_INS);
		ctrl.sample = sample_q;
	end

	assign sel_chain[0] = '0;

	// The sorted row: cell 0 holds the smallest sample.
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swpr_pkg::link_t below;
		swpr_pkg::link_t above;
		logic [AW-1:0]   below_age;
		logic [AW-1:0]   above_age;

		if (i == 0) begin : g_bottom
			// Below the row sits an occupied, never greater, never removed slot.
			assign below     = '{value: '0, occ: 1'b1, gt: 1'b0, del: 1'b0};
			assign below_age = '0;
		end else begin : g_inner_lo
			assign below     = cell_link[i-1];
			assign below_age = cell_age[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_top
			assign above     = '0;
			assign above_age = '0;
		end else begin : g_inner_hi
			assign above     = cell_link[i+1];
			assign above_age = cell_age[i+1];
		end

		swpr_cell #(
			.MAX_WINDOW (MAX_WINDOW),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.oldest_age (oldest_age),
			.rank_lo    (rank_lo_q),
			.rank_hi    (rank_hi_q),
			.below      (below),
			.below_age  (below_age),
			.above      (above),
			.above_age  (above_age),
			.sel_in     (sel_chain[i]),
			.link       (cell_link[i]),
			.age        (cell_age[i]),
			.sel_out    (sel_chain[i+1])
		);
	end

	// Sequencer: the accept cycle drops the oldest sample when the window is
	// full, and the following cycle inserts the new sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Held count and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wl_q    <= swpr_pkg::WL_RESET;
			kf_q    <= swpr_pkg::KF_RESET;
		end else begin
			if (cfg_hit) begin
				count_q <= '0;
				if (cfg_index == swpr_pkg::REG_WINDOW_LENGTH) begin
					wl_q <= cfg_data[swpr_pkg::WL_W-1:0];
				end else begin
					kf_q <= cfg_data[swpr_pkg::KF_W-1:0];
				end
			end else if (ctrl.remove) begin
				count_q <= count_q - CW'(1);
			end else if (ctrl.insert) begin
				count_q <= n_next;
			end
		end
	end

	// The sample is held in a register for its insertion in the following cycle,
	// and the ranks for the next item are worked out while it goes in.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= sample_value;
		end
		if (ctrl.insert) begin
			rank_lo_q <= d_next;
			rank_hi_q <= hi_next;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The range is read from the row as it stands before this item changes it.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			range_valid_q <= (count_q != '0);
			range_low_q   <= (count_q != '0) ? sel_chain[MAX_WINDOW].low  : '0;
			range_high_q  <= (count_q != '0) ? sel_chain[MAX_WINDOW].high : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign range_valid = range_valid_q;
	assign range_low   = range_low_q;
	assign range_high  = range_high_q;

endmodule

// ----- hdl/swpr_checker.sv -----
// ----------------------------------------------------------------------------
// swpr_checker: port-level checks for the percentile range core
// Watches the top-level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module swpr_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              range_valid,
	input  logic [swpr_pkg::DATA_W-1:0]       range_low,
	input  logic [swpr_pkg::DATA_W-1:0]       range_high
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(range_valid) &&
			$stable(range_low) && $stable(range_high))
		else $error("stalled result changed or vanished");

	// An accepted item holds off the next one while it is inserted into the row.
	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted in the insertion cycle");

	// An empty window reports zero cuts.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_valid |-> (range_low == '0) && (range_high == '0))
		else $error("empty window reported nonzero cuts");

	// The low cut never lies above the high cut.
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_valid |-> range_low <= range_high)
		else $error("low cut above high cut");

endmodule

bind sliding_window_percentile_range_core swpr_checker u_swpr_checker (.*);

// ----- verif/tb_sliding_window_percentile_range_core.sv -----
// ----------------------------------------------------------------------------
// tb_sliding_window_percentile_range_core: self-checking bench for the core
// Drives samples and register writes, predicts the trimmed low and high cut
// of the window before every sample, and compares each result item with
// the prediction, with random idle gaps on the sample and result sides.
// ----------------------------------------------------------------------------
module tb_sliding_window_percentile_range_core;

	// Register indexes that select no register. A write to them must leave
	// the window untouched.
	localparam logic [swpr_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [swpr_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	localparam int WINDOW_DEPTH = swpr_pkg::MAX_WINDOW_DEFAULT;
	localparam int RANDOM_ITEMS = 1400;
	// Watchdog limit, with a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT  = 600000;
	// Results owed by the core at any one time; one or two in practice.
	localparam int DUE_DEPTH    = 8;

	typedef struct packed {
		logic                        rv;
		logic [swpr_pkg::DATA_W-1:0] lo;
		logic [swpr_pkg::DATA_W-1:0] hi;
	} range_t;

	typedef enum logic [0:0] {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

	// One row of the directed table. Sample rows may carry a result typed
	// in by hand; the other sample rows are checked against the predictor.
	typedef struct packed {
		row_kind_t                      kind;
		logic [swpr_pkg::CFG_IDX_W-1:0] idx;
		logic [swpr_pkg::DATA_W-1:0]    data;
		logic                           typed;
		range_t                         want;
	} stim_row_t;

	localparam int DIR_ROWS = 32;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [swpr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [swpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [swpr_pkg::DATA_W-1:0]     sample_value = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            range_valid;
	logic [swpr_pkg::DATA_W-1:0]     range_low;
	logic [swpr_pkg::DATA_W-1:0]     range_high;

	sliding_window_percentile_range_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.range_valid  (range_valid),
		.range_low    (range_low),
		.range_high   (range_high)
	);

	always #2 clk = ~clk;

	// Predictor state: a private copy of the window ring and both registers.
	logic [swpr_pkg::DATA_W-1:0] win_ring [WINDOW_DEPTH];
	int unsigned                 held_n = 0;
	int unsigned                 head = 0;
	logic [swpr_pkg::WL_W-1:0]   wl_reg = swpr_pkg::WL_RESET;
	logic [swpr_pkg::KF_W-1:0]   kf_reg = swpr_pkg::KF_RESET;

	// Results still owed by the core, oldest first. The stimulus side only
	// advances the write count and the checker only the read count.
	range_t      due_ring [DUE_DEPTH];
	int unsigned due_wr = 0;
	int unsigned due_rd = 0;

	int range_errors = 0;
	int cycle_count = 0;

	// Idling controls, changed per phase by the stimulus process.
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b1;
	int stall_left = 0;
	int pass_left = 0;
	logic [swpr_pkg::DATA_W-1:0] cluster_base = '0;

	// Work out the range of the window as it stands, then append the new
	// sample and retire the oldest one once the window is over its length.
	function automatic range_t advance_window(input logic [swpr_pkg::DATA_W-1:0] s);
		range_t                      r;
		logic [swpr_pkg::DATA_W-1:0] srt [WINDOW_DEPTH];
		logic [swpr_pkg::DATA_W-1:0] key;
		int unsigned                 len;
		int unsigned                 p;
		int unsigned                 drop;
		int unsigned                 cap;
		int                          i;
		int                          j;
		r = '0;
		// A length of zero behaves as one and anything above the depth
		// saturates to the depth.
		len = 32'(wl_reg);
		if (len < 1)
			len = 1;
		if (len > WINDOW_DEPTH)
			len = WINDOW_DEPTH;
		if (held_n != 0) begin
			for (i = 0; i < int'(held_n); i++)
				srt[i] = win_ring[(head + i) % WINDOW_DEPTH];
			for (i = 1; i < int'(held_n); i++) begin
				key = srt[i];
				j = i;
				while (j > 0 && srt[j-1] > key) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = key;
			end
			// Fractions above one saturate, giving the full min..max span.
			p = 32'(kf_reg);
			if (p > 32'(swpr_pkg::Q_ONE))
				p = 32'(swpr_pkg::Q_ONE);
			drop = ((32'(swpr_pkg::Q_ONE) - p) * held_n + 32'(swpr_pkg::Q_HALF)) >> 16;
			cap = (held_n - 1) / 2;
			if (drop > cap)
				drop = cap;
			r.rv = 1'b1;
			r.lo = srt[drop];
			r.hi = srt[held_n - 1 - drop];
		end
		win_ring[(head + held_n) % WINDOW_DEPTH] = s;
		if (held_n < len) begin
			held_n++;
		end else begin
			head = (head + 1) % WINDOW_DEPTH;
			held_n = len;
		end
		return r;
	endfunction

	function automatic stim_row_t row_s(input logic [swpr_pkg::DATA_W-1:0] d);
		return '{ROW_SAMPLE, '0, d, 1'b0, '0};
	endfunction

	function automatic stim_row_t row_t(input logic [swpr_pkg::DATA_W-1:0] d,
			input logic rv, input logic [swpr_pkg::DATA_W-1:0] lo,
			input logic [swpr_pkg::DATA_W-1:0] hi);
		return '{ROW_SAMPLE, '0, d, 1'b1, '{rv, lo, hi}};
	endfunction

	function automatic stim_row_t row_c(input logic [swpr_pkg::CFG_IDX_W-1:0] idx,
			input logic [swpr_pkg::CFG_DATA_W-1:0] d);
		return '{ROW_CONFIG, idx, swpr_pkg::DATA_W'(d), 1'b0, '0};
	endfunction

	// Idle lengths: mostly none, often short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	// Samples mix the extremes, tight clusters that force ties, values near
	// a per-phase base and fully random words.
	function automatic logic [swpr_pkg::DATA_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return '1;
			2, 3: return swpr_pkg::DATA_W'($urandom_range(0, 7));
			4, 5, 6: return cluster_base + swpr_pkg::DATA_W'($urandom_range(0, 255));
			default: return swpr_pkg::DATA_W'($urandom);
		endcase
	endfunction

	// Window lengths: mostly legal, with zero, saturating values and stray
	// upper data bits mixed in.
	function automatic logic [swpr_pkg::CFG_DATA_W-1:0] pick_length();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0: return '0;
			1: return swpr_pkg::CFG_DATA_W'($urandom_range(17, 31));
			2: return swpr_pkg::CFG_DATA_W'($urandom);
			3, 4: return swpr_pkg::CFG_DATA_W'(16);
			5: return swpr_pkg::CFG_DATA_W'(1);
			default: return swpr_pkg::CFG_DATA_W'($urandom_range(1, 16));
		endcase
	endfunction

	// Fractions: zero, one, exactly one point zero, saturating values and
	// the rest of the legal span.
	function automatic logic [swpr_pkg::CFG_DATA_W-1:0] pick_fraction();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0: return '0;
			1: return swpr_pkg::CFG_DATA_W'(1);
			2: return swpr_pkg::Q_ONE;
			3: return swpr_pkg::CFG_DATA_W'($urandom_range(65537, 131071));
			4: return swpr_pkg::CFG_DATA_W'(65535);
			5: return swpr_pkg::Q_HALF;
			default: return swpr_pkg::CFG_DATA_W'($urandom_range(1, 65536));
		endcase
	endfunction

	// All driving tasks start and end right after a falling edge.
	task automatic idle_sender(input int k);
		if (k > 0) begin
			in_valid = 1'b0;
			repeat (k) @(negedge clk);
		end
	endtask

	// Offer one sample and hold it until the core takes it. The expected
	// range goes into the ring at the accepting edge.
	task automatic push_sample(input logic [swpr_pkg::DATA_W-1:0] v, input logic typed,
			input range_t want);
		range_t predicted;
		in_valid = 1'b1;
		sample_value = v;
		do
			@(posedge clk);
		while (in_stall);
		predicted = advance_window(v);
		due_ring[due_wr % DUE_DEPTH] = typed ? want : predicted;
		due_wr++;
		@(negedge clk);
	endtask

	// Stop offering samples until every owed result has come back.
	task automatic wait_drained();
		in_valid = 1'b0;
		while (due_wr != due_rd)
			@(negedge clk);
	endtask

	// Register writes happen only with the core idle. The wait after the last
	// result also covers the insert that follows each accepted sample.
	task automatic write_register(input logic [swpr_pkg::CFG_IDX_W-1:0] idx,
			input logic [swpr_pkg::CFG_DATA_W-1:0] d);
		wait_drained();
		repeat (2) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_data = swpr_pkg::CFG_DATA_W'($urandom);
		// Either real register clears the window, even when the value is
		// unchanged; the unused indexes change nothing at all.
		if (idx == swpr_pkg::REG_WINDOW_LENGTH) begin
			wl_reg = d[swpr_pkg::WL_W-1:0];
			held_n = 0;
			head = 0;
		end else if (idx == swpr_pkg::REG_KEEP_FRACTION) begin
			kf_reg = d;
			held_n = 0;
			head = 0;
		end
	endtask

	// Result side: stall in bursts, mostly short and a few long, with quiet
	// phases where the result side never stalls.
	always @(negedge clk) begin
		if (rx_quiet || !arst_n) begin
			out_stall = 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
			if (pass_left > 0) begin
				pass_left--;
			end else begin
				stall_left = pick_gap();
				pass_left = $urandom_range(0, 6);
			end
		end
	end

	// Every accepted result is checked field by field against the oldest
	// expectation. A result with nothing owed is a failure on its own.
	always @(posedge clk) begin
		range_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (due_wr == due_rd) begin
				$display("%0t: unexpected result item valid %b low %h high %h",
					$time, range_valid, range_low, range_high);
				range_errors++;
			end else begin
				exp_r = due_ring[due_rd % DUE_DEPTH];
				due_rd++;
				if (range_valid !== exp_r.rv) begin
					$display("%0t: range_valid expected %b actual %b",
						$time, exp_r.rv, range_valid);
					range_errors++;
				end
				if (range_low !== exp_r.lo) begin
					$display("%0t: range_low expected %h actual %h",
						$time, exp_r.lo, range_low);
					range_errors++;
				end
				if (range_high !== exp_r.hi) begin
					$display("%0t: range_high expected %h actual %h",
						$time, exp_r.hi, range_high);
					range_errors++;
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sliding_window_percentile_range_core: mismatch");
			$finish;
		end
	end

	initial begin
		stim_row_t dir_rows [DIR_ROWS];
		int        sent;
		int        phase_items;
		int        k;
		int        choice;

		dir_rows = '{
			// After reset the window is empty, then a single sample is both cuts.
			row_t(32'hFFFFFFFF, 1'b0, 32'h0, 32'h0),
			row_t(32'h00000000, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF),
			row_s(32'd7), row_s(32'd5), row_s(32'd5),
			row_s(32'h80000000), row_s(32'h7FFFFFFF), row_s(32'd1),
			// Length one: after the first, each result is the previous sample.
			row_c(swpr_pkg::REG_WINDOW_LENGTH, 17'd1),
			row_t(32'hA5A5A5A5, 1'b0, 32'h0, 32'h0),
			row_t(32'h5A5A5A5A, 1'b1, 32'hA5A5A5A5, 32'hA5A5A5A5),
			row_t(32'd3, 1'b1, 32'h5A5A5A5A, 32'h5A5A5A5A),
			// Length zero behaves as length one.
			row_c(swpr_pkg::REG_WINDOW_LENGTH, 17'd0),
			row_t(32'd9, 1'b0, 32'h0, 32'h0),
			row_t(32'd10, 1'b1, 32'd9, 32'd9),
			// All data bits set: the length saturates to the full depth.
			row_c(swpr_pkg::REG_WINDOW_LENGTH, 17'h1FFFF),
			// Fraction zero keeps only the median.
			row_c(swpr_pkg::REG_KEEP_FRACTION, 17'd0),
			row_t(32'd4, 1'b0, 32'h0, 32'h0),
			row_s(32'd8), row_s(32'd2), row_s(32'd6),
			// An unused index must not clear the window.
			row_c(REG_UNUSED_2, 17'h1FFFF),
			row_s(32'd1),
			// A fraction above one saturates to the full span.
			row_c(swpr_pkg::REG_KEEP_FRACTION, 17'h1FFFF),
			row_t(32'hFFFFFFFF, 1'b0, 32'h0, 32'h0),
			row_t(32'h00000000, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF),
			row_s(32'd12),
			row_c(REG_UNUSED_3, 17'd0),
			row_s(32'd0),
			// Exactly one point zero.
			row_c(swpr_pkg::REG_KEEP_FRACTION, swpr_pkg::Q_ONE),
			row_t(32'd3, 1'b0, 32'h0, 32'h0),
			row_t(32'd1, 1'b1, 32'd3, 32'd3)
		};

		// Reset once, released on a falling edge.
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: receiver never stalls at first, then random idling.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == 16)
				rx_quiet = 1'b0;
			if (dir_rows[i].kind == ROW_CONFIG) begin
				write_register(dir_rows[i].idx,
					dir_rows[i].data[swpr_pkg::CFG_DATA_W-1:0]);
			end else begin
				push_sample(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
				idle_sender(pick_gap());
			end
		end

		// Random part, in phases. Each phase may change the registers, picks
		// its own idling mode and runs a burst of samples.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			choice = $urandom_range(0, 9);
			case (choice)
				0, 1, 2, 3: write_register(swpr_pkg::REG_WINDOW_LENGTH, pick_length());
				4, 5, 6: write_register(swpr_pkg::REG_KEEP_FRACTION, pick_fraction());
				7: begin
					write_register(swpr_pkg::REG_WINDOW_LENGTH, pick_length());
					write_register(swpr_pkg::REG_KEEP_FRACTION, pick_fraction());
				end
				8: write_register($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
					swpr_pkg::CFG_DATA_W'($urandom));
				default: ;
			endcase
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			cluster_base = swpr_pkg::DATA_W'($urandom);
			phase_items = $urandom_range(40, 160);
			for (k = 0; k < phase_items && sent < RANDOM_ITEMS; k++) begin
				push_sample(pick_sample(), 1'b0, '0);
				sent++;
				// Occasionally hold back until the core has caught up.
				if ($urandom_range(0, 299) == 0)
					wait_drained();
				idle_sender(tx_quiet ? 0 : pick_gap());
			end
		end

		// Wait for the last results, then wait on to catch any extras.
		wait_drained();
		repeat (8) @(negedge clk);
		if (range_errors == 0)
			$display("sliding_window_percentile_range_core: match");
		else
			$display("sliding_window_percentile_range_core: mismatch");
		$finish;
	end

endmodule
